@@ src/cgcs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Channel group coincidence select package
// Shared widths, register indexes and the state machine encoding.
// ----------------------------------------------------------------------------
package cgcs_pkg;

    localparam int MAX_CHANNELS = 64;
    localparam int CH_W = 6;
    localparam int TIME_W = 20;
    localparam int AMP_W = 16;
    localparam int CFG_W = 64;
    localparam int IDX_W = 3;

    localparam logic [IDX_W-1:0] REG_GROUP_MASK   = 3'd0;
    localparam logic [IDX_W-1:0] REG_SPECIAL_MASK = 3'd1;
    localparam logic [IDX_W-1:0] REG_WIN_START    = 3'd2;
    localparam logic [IDX_W-1:0] REG_WIN_END      = 3'd3;
    localparam logic [IDX_W-1:0] REG_THR_NORMAL   = 3'd4;
    localparam logic [IDX_W-1:0] REG_THR_SPECIAL  = 3'd5;

    localparam logic [63:0] SPECIAL_MASK_RESET = 64'h0000_0000_0040_0020;

    typedef enum logic [2:0] {
        ST_COLLECT,
        ST_CHECK,
        ST_SCAN,
        ST_EMIT,
        ST_REJECT
    } state_t;

endpackage

@@ src/channel_group_coincidence_select.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Channel group coincidence select
// Keeps the earliest in-window pulse per group channel and emits the event.
// ----------------------------------------------------------------------------
// Flow: a pulse is read in its accept cycle and written back in the next one;
// after the event end pulse a check pass reads every channel, then each kept
// pulse costs a scan over every channel and one output (a reject gives one).
// Throughput: 1 pulse per cycle while collecting, with a pause after event end;
// the single read port of the hit memory sets the check and scan lengths.
// Reset clears the valid bits and state at once; there is no clearing pass.
module channel_group_coincidence_select #(
    parameter int NUM_CHANNELS = cgcs_pkg::MAX_CHANNELS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // channel[5:0], height[21:6], arrival[41:22], charge[57:42],
    // arrival_cal[77:58], zeros[79:78]
    input  logic [79:0] s_tdata,
    input  logic        s_tlast,   // event_end
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_channel[5:0], out_height[21:6], out_arrival[41:22], out_charge[57:42],
    // out_arrival_cal[77:58], zeros[79:78]
    output logic [79:0] m_tdata,
    output logic        m_tuser,   // event_pass
    output logic        m_tlast,   // last_of_event
    input  logic        cfg_we,
    input  logic [cgcs_pkg::IDX_W-1:0] cfg_index,
    input  logic [cgcs_pkg::CFG_W-1:0] cfg_data
);
    localparam int CW = cgcs_pkg::CH_W;
    localparam int TW = cgcs_pkg::TIME_W;
    localparam int AW = cgcs_pkg::AMP_W;
    localparam int EW = TW + AW + AW + TW;   // time, height, charge, cal
    localparam int NW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CNT_W = $clog2(NUM_CHANNELS + 1);

    logic [63:0] group_reg, special_reg;
    logic signed [TW-1:0] wstart_reg, wend_reg;
    logic [AW-1:0] thr_n_reg, thr_s_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_reg   <= '0;
            special_reg <= cgcs_pkg::SPECIAL_MASK_RESET;
            wstart_reg  <= '0;
            wend_reg    <= '0;
            thr_n_reg   <= '0;
            thr_s_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cgcs_pkg::REG_GROUP_MASK:   group_reg   <= cfg_data;
                cgcs_pkg::REG_SPECIAL_MASK: special_reg <= cfg_data;
                cgcs_pkg::REG_WIN_START:    wstart_reg  <= cfg_data[TW-1:0];
                cgcs_pkg::REG_WIN_END:      wend_reg    <= cfg_data[TW-1:0];
                cgcs_pkg::REG_THR_NORMAL:   thr_n_reg   <= cfg_data[AW-1:0];
                cgcs_pkg::REG_THR_SPECIAL:  thr_s_reg   <= cfg_data[AW-1:0];
                default: ;
            endcase
        end
    end

    // Hit memory: one write port and one registered read port.
    logic [EW-1:0] mem [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] valid_reg, valid_next;
    logic [NUM_CHANNELS-1:0] emitted_reg, emitted_next;
    logic          mem_we;
    logic [NW-1:0] mem_waddr, mem_raddr;
    logic [EW-1:0] mem_wdata, rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rdata_reg <= mem[mem_raddr];
    end

    // Pulse fields.
    logic [CW-1:0] in_ch;
    logic signed [TW-1:0] in_t;
    assign in_ch = s_tdata[5:0];
    assign in_t  = s_tdata[41:22];

    // Pipeline stage: pulse read issued, compare next cycle.
    logic          p_v_reg, p_last_reg, p_hit_reg;
    logic [NW-1:0] p_ch_reg;
    logic [EW-1:0] p_data_reg;
    logic [EW-1:0] old_entry;

    logic [63:0] grp;
    always_comb
    begin
        grp = '0;
        grp[NUM_CHANNELS-1:0] = group_reg[NUM_CHANNELS-1:0];
    end

    cgcs_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic pass_reg, pass_next;
    logic [CNT_W-1:0] left_reg, left_next;  // pulses still to emit
    logic best_v_reg, best_v_next;
    logic [NW-1:0] best_ch_reg, best_ch_next;
    logic [EW-1:0] best_reg, best_next;
    logic [NW-1:0] rd_ch_reg;
    logic [79:0] m_data_reg, m_data_next;
    logic m_valid_reg, m_valid_next, m_pass_reg, m_pass_next, m_last_reg, m_last_next;
    logic accept;

    assign s_tready = (state_reg == cgcs_pkg::ST_COLLECT) && !(p_v_reg && p_last_reg);
    assign accept = s_tvalid && s_tready;

    assign old_entry = rdata_reg;

    // Forward the same-channel write from the stage ahead.
    logic fwd_reg;
    logic [EW-1:0] fwd_data_reg;
    logic [EW-1:0] cur_entry;
    assign cur_entry = fwd_reg ? fwd_data_reg : old_entry;
    logic replace_c;
    assign replace_c = p_hit_reg && (!valid_reg[p_ch_reg] ||
                       $signed(p_data_reg[TW-1:0]) < $signed(cur_entry[TW-1:0]));

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        pass_next    = pass_reg;
        left_next    = left_reg;
        best_v_next  = best_v_reg;
        best_ch_next = best_ch_reg;
        best_next    = best_reg;
        valid_next   = valid_reg;
        emitted_next = emitted_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_pass_next  = m_pass_reg;
        m_last_next  = m_last_reg;
        mem_we       = 1'b0;
        mem_waddr    = p_ch_reg;
        mem_wdata    = p_data_reg;
        mem_raddr    = in_ch[NW-1:0];

        if (p_v_reg && replace_c)
        begin
            mem_we = 1'b1;
            valid_next[p_ch_reg] = 1'b1;
        end

        case (state_reg)
            cgcs_pkg::ST_COLLECT:
            begin
                if (p_v_reg && p_last_reg)
                begin
                    state_next = cgcs_pkg::ST_CHECK;
                    idx_next   = '0;
                    pass_next  = (grp != 64'd0);
                    left_next  = '0;
                    mem_raddr  = '0;
                end
            end
            cgcs_pkg::ST_CHECK:
            begin
                // One channel per cycle: the data read at idx - 1 is tested here.
                mem_raddr = NW'(idx_reg);
                if (idx_reg != '0)
                begin
                    if (grp[rd_ch_reg])
                    begin
                        left_next = left_reg + 1'b1;
                        if (!valid_reg[rd_ch_reg])
                            pass_next = 1'b0;
                        else if (rdata_reg[TW+AW+AW-1:TW+AW] <
                                 (special_reg[rd_ch_reg] ? thr_s_reg : thr_n_reg))
                            pass_next = 1'b0;
                    end
                end
                if (idx_reg == CNT_W'(NUM_CHANNELS))
                begin
                    idx_next = '0;
                    emitted_next = '0;
                    best_v_next = 1'b0;
                    mem_raddr = '0;
                    state_next = pass_next ? cgcs_pkg::ST_SCAN : cgcs_pkg::ST_REJECT;
                end
                else
                    idx_next = idx_reg + 1'b1;
            end
            cgcs_pkg::ST_SCAN:
            begin
                // Find the earliest not yet emitted group pulse; channels come in
                // ascending order, so strict less keeps the lower one on equal times.
                mem_raddr = NW'(idx_reg);
                if (idx_reg != '0 && grp[rd_ch_reg] && !emitted_reg[rd_ch_reg])
                begin
                    if (!best_v_reg ||
                        $signed(rdata_reg[TW-1:0]) < $signed(best_reg[TW-1:0]))
                    begin
                        best_v_next  = 1'b1;
                        best_ch_next = rd_ch_reg;
                        best_next    = rdata_reg;
                    end
                end
                if (idx_reg == CNT_W'(NUM_CHANNELS))
                begin
                    mem_raddr  = '0;
                    state_next = cgcs_pkg::ST_EMIT;
                end
                else
                    idx_next = idx_reg + 1'b1;
            end
            cgcs_pkg::ST_EMIT:
            begin
                mem_raddr = '0;
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_pass_next  = 1'b1;
                    m_last_next  = (left_reg == CNT_W'(1));
                    m_data_next  = {2'b00, best_reg[EW-1:TW+AW+AW],
                                    best_reg[TW+AW+AW-1:TW+AW], best_reg[TW-1:0],
                                    best_reg[TW+AW-1:TW], CW'(best_ch_reg)};
                    emitted_next[best_ch_reg] = 1'b1;
                    left_next   = left_reg - 1'b1;
                    best_v_next = 1'b0;
                    idx_next    = '0;
                    if (left_reg == CNT_W'(1))
                    begin
                        valid_next = '0;
                        state_next = cgcs_pkg::ST_COLLECT;
                    end
                    else
                        state_next = cgcs_pkg::ST_SCAN;
                end
            end
            cgcs_pkg::ST_REJECT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_pass_next  = 1'b0;
                    m_last_next  = 1'b1;
                    m_data_next  = '0;
                    valid_next   = '0;
                    state_next   = cgcs_pkg::ST_COLLECT;
                end
            end
            default: state_next = cgcs_pkg::ST_COLLECT;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= cgcs_pkg::ST_COLLECT;
            idx_reg     <= '0;
            pass_reg    <= 1'b0;
            left_reg    <= '0;
            best_v_reg  <= 1'b0;
            valid_reg   <= '0;
            emitted_reg <= '0;
            m_valid_reg <= 1'b0;
            p_v_reg     <= 1'b0;
            p_last_reg  <= 1'b0;
            p_hit_reg   <= 1'b0;
            fwd_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            pass_reg    <= pass_next;
            left_reg    <= left_next;
            best_v_reg  <= best_v_next;
            valid_reg   <= valid_next;
            emitted_reg <= emitted_next;
            m_valid_reg <= m_valid_next;
            p_v_reg     <= accept;
            p_last_reg  <= accept && s_tlast;
            p_hit_reg   <= accept && (int'(in_ch) < NUM_CHANNELS) && grp[in_ch] &&
                           (in_t > wstart_reg) && (in_t < wend_reg);
            fwd_reg     <= mem_we && (mem_waddr == mem_raddr);
        end
    end

    always_ff @(posedge clk)
    begin
        p_ch_reg     <= in_ch[NW-1:0];
        p_data_reg   <= {s_tdata[77:58], s_tdata[57:42], s_tdata[21:6], s_tdata[41:22]};
        fwd_data_reg <= mem_wdata;
        rd_ch_reg    <= mem_raddr;
        best_ch_reg  <= best_ch_next;
        best_reg     <= best_next;
        m_data_reg   <= m_data_next;
        m_pass_reg   <= m_pass_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_pass_reg;
    assign m_tlast  = m_last_reg;

endmodule

@@ tb/sv/channel_group_coincidence_select_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Channel group coincidence select testbench
// Drives detector pulses with random flow control, predicts the kept pulses
// of each event in time order (or the reject) and checks every result.
// ----------------------------------------------------------------------------
module channel_group_coincidence_select_tb;

    typedef struct packed {
        logic        pass;
        logic [5:0]  chan;
        logic [15:0] height;
        logic [19:0] arrival;
        logic [15:0] charge;
        logic [19:0] arrival_cal;
        logic        last;
    } pulse_out_t;

    // An index past the register list; writes to it change nothing.
    localparam logic [cgcs_pkg::IDX_W-1:0] REG_NONE = 3'd7;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_we;
    logic [cgcs_pkg::IDX_W-1:0] cfg_index;
    logic [cgcs_pkg::CFG_W-1:0] cfg_data;

    // Predictor copy of registers and the per-channel hit store.
    logic [63:0]        grp_mask;
    logic [63:0]        spc_mask;
    logic signed [19:0] win_lo;
    logic signed [19:0] win_hi;
    logic [15:0]        thr_norm;
    logic [15:0]        thr_spc;
    logic               kept_valid [64];
    logic signed [19:0] kept_time [64];
    logic [15:0]        kept_height [64];
    logic [15:0]        kept_charge [64];
    logic [19:0]        kept_cal [64];

    pulse_out_t expected_pulses[$];
    int         mismatches;
    int         cycles;
    int         send_idle_pct;
    int         recv_idle_pct;

    channel_group_coincidence_select uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 10000000)
        begin
            $display("channel_group_coincidence_select_tb NOT OK");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Result checker.
    always @(posedge clk)
    begin
        pulse_out_t got;
        pulse_out_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tuser, m_tdata[5:0], m_tdata[21:6], m_tdata[41:22],
                   m_tdata[57:42], m_tdata[77:58], m_tlast};
            if (expected_pulses.size() == 0)
            begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("unexpected result %h", got);
            end
            else
            begin
                want = expected_pulses.pop_front();
                if (got !== want)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h actual %h", want, got);
                end
            end
        end
    end

    task automatic add_expected(input pulse_out_t r);
        expected_pulses = {expected_pulses, r};
    endtask

    task automatic write_reg(input logic [cgcs_pkg::IDX_W-1:0] idx, input logic [63:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            cgcs_pkg::REG_GROUP_MASK:   grp_mask = val;
            cgcs_pkg::REG_SPECIAL_MASK: spc_mask = val;
            cgcs_pkg::REG_WIN_START:    win_lo = val[19:0];
            cgcs_pkg::REG_WIN_END:      win_hi = val[19:0];
            cgcs_pkg::REG_THR_NORMAL:   thr_norm = val[15:0];
            cgcs_pkg::REG_THR_SPECIAL:  thr_spc = val[15:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic predict_pulse(input logic [5:0] ch, input logic [15:0] h,
                                 input logic signed [19:0] t, input logic [15:0] q,
                                 input logic [19:0] tc, input logic fin);
        logic   ok;
        int     order[$];
        int     j;
        logic [15:0] thr;
        pulse_out_t r;
        if (grp_mask[ch] && t > win_lo && t < win_hi
            && (!kept_valid[ch] || t < kept_time[ch]))
        begin
            kept_valid[ch] = 1'b1;
            kept_time[ch] = t;
            kept_height[ch] = h;
            kept_charge[ch] = q;
            kept_cal[ch] = tc;
        end
        if (!fin)
            return;
        ok = (grp_mask != 0);
        for (int i = 0; i < 64; i++)
        begin
            if (grp_mask[i])
            begin
                thr = spc_mask[i] ? thr_spc : thr_norm;
                if (!kept_valid[i] || kept_charge[i] < thr)
                    ok = 1'b0;
            end
        end
        if (!ok)
            add_expected('{1'b0, 6'd0, 16'd0, 20'd0, 16'd0, 20'd0, 1'b1});
        else
        begin
            // Stable insertion keeps equal times in ascending channel order.
            for (int i = 0; i < 64; i++)
            begin
                if (grp_mask[i])
                begin
                    j = order.size();
                    while (j > 0 && kept_time[order[j-1]] > kept_time[i])
                        j--;
                    order.insert(j, i);
                end
            end
            foreach (order[k])
            begin
                r = '{1'b1, order[k][5:0], kept_height[order[k]], kept_time[order[k]],
                      kept_charge[order[k]], kept_cal[order[k]], k == order.size() - 1};
                add_expected(r);
            end
        end
        for (int i = 0; i < 64; i++)
            kept_valid[i] = 1'b0;
    endtask

    // The request stays valid after acceptance; drain or the next idle drops it.
    task automatic send_pulse(input logic [5:0] ch, input logic [15:0] h,
                              input logic [19:0] t, input logic [15:0] q,
                              input logic [19:0] tc, input logic fin);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, tc, q, t, h, ch};
        s_tlast <= fin;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_pulse(ch, h, t, q, tc, fin);
    endtask

    // Waits for all results, then for the longest event drain.
    task automatic drain;
        s_tvalid <= 1'b0;
        while (expected_pulses.size() != 0)
            @(posedge clk);
        repeat (200)
            @(posedge clk);
    endtask

    task automatic send_event(input int n_pulses);
        int idx[$];
        logic [5:0] ch;
        logic signed [19:0] t;
        for (int i = 0; i < 64; i++)
            if (grp_mask[i])
                idx = {idx, i};
        for (int p = 0; p < n_pulses; p++)
        begin
            if (idx.size() != 0 && $urandom_range(9) < 8)
                ch = 6'(idx[$urandom_range(idx.size() - 1)]);
            else
                ch = 6'($urandom);
            if ($urandom_range(9) < 8 && win_hi - win_lo > 1)
                t = 20'(win_lo + 1 + $urandom_range(win_hi - win_lo - 2));
            else
                t = 20'($urandom);
            if ($urandom_range(9) == 0 && kept_valid[ch])
                t = kept_time[ch];
            send_pulse(ch, 16'($urandom), t,
                       $urandom_range(9) < 7 ? 16'(16'hFFFF - $urandom_range(300))
                       : 16'($urandom), 20'($urandom), p == n_pulses - 1);
        end
    endtask

    task automatic test_directed;
        write_reg(cgcs_pkg::REG_GROUP_MASK, 64'h0);
        send_pulse(6'd0, 16'd1, 20'd1, 16'd1, 20'd1, 1'b1);
        drain();
        write_reg(cgcs_pkg::REG_GROUP_MASK, 64'h8000_0000_0040_0021);
        write_reg(cgcs_pkg::REG_WIN_START, 64'hF_FFF0);
        write_reg(cgcs_pkg::REG_WIN_END, 64'd100);
        write_reg(cgcs_pkg::REG_THR_NORMAL, 64'd16);
        write_reg(cgcs_pkg::REG_THR_SPECIAL, 64'd32);
        // Tie on channel 0 keeps the first pulse; channel 63 shares its time.
        send_pulse(6'd0, 16'hFFFF, 20'd5, 16'd16, 20'h80000, 1'b0);
        send_pulse(6'd0, 16'h0, 20'd5, 16'd100, 20'h7FFFF, 1'b0);
        send_pulse(6'd63, 16'h1234, 20'd5, 16'hFFFF, 20'd0, 1'b0);
        send_pulse(6'd22, 16'h1, 20'hF_FFF1, 16'd32, 20'd3, 1'b0);
        send_pulse(6'd5, 16'h2, 20'd99, 16'd40, 20'd4, 1'b1);
        // Window edges are excluded, and a special channel below threshold fails.
        send_pulse(6'd0, 16'h3, 20'hF_FFF0, 16'd20, 20'd0, 1'b0);
        send_pulse(6'd0, 16'h3, 20'd100, 16'd20, 20'd0, 1'b0);
        send_pulse(6'd63, 16'h3, 20'd10, 16'd20, 20'd0, 1'b0);
        send_pulse(6'd22, 16'h3, 20'd11, 16'd31, 20'd0, 1'b0);
        send_pulse(6'd5, 16'h3, 20'd12, 16'd31, 20'd0, 1'b1);
        drain();
        // Inverted window and extreme registers.
        write_reg(cgcs_pkg::REG_GROUP_MASK, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(cgcs_pkg::REG_SPECIAL_MASK, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(cgcs_pkg::REG_WIN_START, 64'h7_FFFF);
        write_reg(cgcs_pkg::REG_WIN_END, 64'h8_0000);
        write_reg(cgcs_pkg::REG_THR_NORMAL, 64'hFFFF);
        write_reg(cgcs_pkg::REG_THR_SPECIAL, 64'hFFFF);
        send_pulse(6'd7, 16'd0, 20'd0, 16'hFFFF, 20'd0, 1'b1);
        drain();
        write_reg(REG_NONE, 64'hDEAD);
    endtask

    task automatic test_random(input int n_items, input logic [63:0] grp,
                               input logic signed [19:0] lo, input logic signed [19:0] hi);
        int sent;
        int n;
        write_reg(cgcs_pkg::REG_GROUP_MASK, grp);
        write_reg(cgcs_pkg::REG_SPECIAL_MASK, {$urandom, $urandom});
        write_reg(cgcs_pkg::REG_WIN_START, 64'(lo));
        write_reg(cgcs_pkg::REG_WIN_END, 64'(hi));
        write_reg(cgcs_pkg::REG_THR_NORMAL, 64'($urandom_range(65535)));
        write_reg(cgcs_pkg::REG_THR_SPECIAL, 64'($urandom_range(65535)));
        sent = 0;
        while (sent < n_items)
        begin
            n = 1 + $urandom_range(2 * $countones(grp) + 1);
            send_event(n);
            sent += n;
        end
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cycles = 0;
        mismatches = 0;
        grp_mask = 64'h0;
        spc_mask = cgcs_pkg::SPECIAL_MASK_RESET;
        win_lo = 0;
        win_hi = 0;
        thr_norm = 0;
        thr_spc = 0;
        for (int i = 0; i < 64; i++)
            kept_valid[i] = 1'b0;
        send_idle_pct = 26;
        recv_idle_pct = 80;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(100, 64'h0000_0000_0040_0021, -20'sd200, 20'sd300);
        send_idle_pct = 80;
        recv_idle_pct = 26;
        test_random(100, {32'h0, $urandom} & 64'h0000_0000_0000_0F0F, -20'sd524288, 20'sd524287);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(90, 64'h8000_0000_0000_0003, -20'sd50, 20'sd50);
        if (mismatches == 0)
            $display("channel_group_coincidence_select_tb OK");
        else
            $display("channel_group_coincidence_select_tb NOT OK");
        $finish;
    end

endmodule
